// File: rtl/table_linear_interpolator_macros.svh
// Assertion macros shared by the interpolator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TLI_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tli_pkg.sv
// Shared types and constants of the table linear interpolator.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps

package tli_pkg;

    // Command codes carried in the input tuser bit.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Fixed field widths of the interface.
    localparam int IDX_W = 8;
    localparam int CFG_W = 9;

    // Reset value of the breakpoint count register.
    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_LO,
        ST_CHK_HI,
        ST_SCAN,
        ST_SUB_HQ,
        ST_SUB_QL,
        ST_SUB_D,
        ST_MUL,
        ST_DIV_CHK,
        ST_DIV,
        ST_PUSH
    } tli_state_t;

    // Operations of the shared adder.
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } tli_alu_op_t;

    // Table access controls for one cycle.
    typedef struct packed {
        logic wr_en;
        logic abs_rd_en;
        logic val_rd_en;
    } tli_mem_req_t;

    // Finished request handed to the output register.
    typedef struct packed {
        logic valid;
        logic oor;
    } tli_res_t;

endpackage

// File: rtl/tli_alu.sv
// Shared wide adder/subtractor of the interpolator sequencer.
// Depends on tli_pkg for the operation type.
`timescale 1ns / 1ps

module tli_alu #(
    parameter int W = 64
) (
    input  tli_pkg::tli_alu_op_t op,
    input  logic [W-1:0]         a,
    input  logic [W-1:0]         b,
    output logic [W-1:0]         sum,
    output logic                 carry
);

    logic [W:0] full;

    // Subtraction adds the inverted operand plus one, so carry means a >= b.
    always_comb begin
        unique case (op)
            tli_pkg::ALU_ADD: full = {1'b0, a} + {1'b0, b};
            tli_pkg::ALU_SUB: full = {1'b0, a} + {1'b0, ~b} + (W+1)'(1);
            default:          full = '0;
        endcase
    end

    assign sum   = full[W-1:0];
    assign carry = full[W];

endmodule

// File: rtl/tli_table.sv
// Breakpoint memories: abscissas and values, one write and one registered read each.
// Depends on tli_pkg for the access control struct.
`timescale 1ns / 1ps

module tli_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int DATA_WIDTH  = 32,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                    aclk,
    input  tli_pkg::tli_mem_req_t   req,
    input  logic [AW-1:0]           wr_addr,
    input  logic [DATA_WIDTH-1:0]   wr_abscissa,
    input  logic [DATA_WIDTH-1:0]   wr_value,
    input  logic [AW-1:0]           abs_rd_addr,
    input  logic [AW-1:0]           val_rd_addr,
    output logic [DATA_WIDTH-1:0]   abs_rd_data,
    output logic [DATA_WIDTH-1:0]   val_rd_data
);

    logic [DATA_WIDTH-1:0] abs_mem [TABLE_DEPTH];
    logic [DATA_WIDTH-1:0] val_mem [TABLE_DEPTH];

    // Abscissa memory with registered read.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            abs_mem[wr_addr] <= wr_abscissa;
        end
        if (req.abs_rd_en) begin
            abs_rd_data <= abs_mem[abs_rd_addr];
        end
    end

    // Value memory with registered read.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            val_mem[wr_addr] <= wr_value;
        end
        if (req.val_rd_en) begin
            val_rd_data <= val_mem[val_rd_addr];
        end
    end

endmodule

// File: rtl/tli_ctrl.sv
// Sequencer and datapath registers of the interpolator: range checks, scan,
// shift-add multiply and restoring divide, all on the shared adder.
// Depends on tli_pkg, table_linear_interpolator_macros.svh, tli_alu and tli_table ports.
`timescale 1ns / 1ps
`include "table_linear_interpolator_macros.svh"

module tli_ctrl #(
    parameter int TABLE_DEPTH = 256,
    parameter int DATA_WIDTH  = 32,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int W  = 2 * DATA_WIDTH,
    localparam int CW = $clog2(DATA_WIDTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [tli_pkg::CFG_W-1:0]   points_in_use,
    // Input request handshake and the fields the sequencer needs.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic                        s_command,
    input  logic [tli_pkg::IDX_W-1:0]   s_entry_index,
    input  logic [DATA_WIDTH-1:0]       s_query_abscissa,
    // Table access.
    output tli_pkg::tli_mem_req_t       mem_req,
    output logic [AW-1:0]               wr_addr,
    output logic [AW-1:0]               abs_rd_addr,
    output logic [AW-1:0]               val_rd_addr,
    input  logic [DATA_WIDTH-1:0]       abs_rd_data,
    input  logic [DATA_WIDTH-1:0]       val_rd_data,
    // Shared adder.
    output tli_pkg::tli_alu_op_t        alu_op,
    output logic [W-1:0]                alu_a,
    output logic [W-1:0]                alu_b,
    input  logic [W-1:0]                alu_sum,
    input  logic                        alu_carry,
    // Finished result.
    output tli_pkg::tli_res_t           res,
    output logic [DATA_WIDTH-1:0]       res_value,
    input  logic                        out_free
);

    localparam logic [CW-1:0] CNT_LAST = CW'(DATA_WIDTH - 1);

    tli_pkg::tli_state_t state_reg, state_next;

    logic [AW-1:0]         idx_reg, idx_next;
    logic [AW-1:0]         last_reg, last_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  pass_reg, pass_next;
    logic [DATA_WIDTH-1:0] q_reg, q_next;
    logic [DATA_WIDTH-1:0] lo_reg, lo_next;
    logic [DATA_WIDTH-1:0] hi_reg, hi_next;
    logic [DATA_WIDTH-1:0] d_reg, d_next;
    logic [DATA_WIDTH-1:0] t_reg, t_next;
    logic [DATA_WIDTH-1:0] vn_reg, vn_next;
    logic [DATA_WIDTH-1:0] mplr_reg, mplr_next;
    logic [W-1:0]          mcand_reg, mcand_next;
    logic [W-1:0]          acc_reg, acc_next;
    logic [DATA_WIDTH:0]   rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    logic                  oor_reg, oor_next;

    logic                  ge;
    logic                  accept;
    logic                  cnt_done;
    logic [31:0]           pts_ext;
    logic [DATA_WIDTH:0]   div_shift;

    assign ge        = alu_carry;
    assign accept    = s_tvalid && s_tready;
    assign cnt_done  = (cnt_reg == CNT_LAST);
    assign pts_ext   = 32'(points_in_use);
    assign div_shift = {rem_reg[DATA_WIDTH-1:0], acc_reg[DATA_WIDTH-1]};
    assign wr_addr   = AW'(s_entry_index);
    assign res_value = res_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tli_pkg::ST_IDLE: begin
                if (accept && s_command == tli_pkg::CMD_QUERY) begin
                    state_next = tli_pkg::ST_CHK_LO;
                end
            end
            tli_pkg::ST_CHK_LO:  state_next = ge ? tli_pkg::ST_PUSH : tli_pkg::ST_CHK_HI;
            tli_pkg::ST_CHK_HI:  state_next = ge ? tli_pkg::ST_PUSH : tli_pkg::ST_SCAN;
            tli_pkg::ST_SCAN:    state_next = ge ? tli_pkg::ST_SCAN : tli_pkg::ST_SUB_HQ;
            tli_pkg::ST_SUB_HQ:  state_next = tli_pkg::ST_SUB_QL;
            tli_pkg::ST_SUB_QL:  state_next = tli_pkg::ST_SUB_D;
            tli_pkg::ST_SUB_D:   state_next = tli_pkg::ST_MUL;
            tli_pkg::ST_MUL: begin
                if (cnt_done && pass_reg) begin
                    state_next = tli_pkg::ST_DIV_CHK;
                end
            end
            tli_pkg::ST_DIV_CHK: state_next = ge ? tli_pkg::ST_PUSH : tli_pkg::ST_DIV;
            tli_pkg::ST_DIV: begin
                if (cnt_done) begin
                    state_next = tli_pkg::ST_PUSH;
                end
            end
            tli_pkg::ST_PUSH: begin
                if (out_free) begin
                    state_next = tli_pkg::ST_IDLE;
                end
            end
            default: state_next = tli_pkg::ST_IDLE;
        endcase
    end

    // Handshake, table and adder controls for the current state.
    always_comb begin
        s_tready          = 1'b0;
        mem_req           = '0;
        abs_rd_addr       = '0;
        val_rd_addr       = '0;
        alu_op            = tli_pkg::ALU_SUB;
        alu_a             = '0;
        alu_b             = '0;
        res               = '0;
        unique case (state_reg)
            tli_pkg::ST_IDLE: begin
                s_tready          = 1'b1;
                mem_req.wr_en     = s_tvalid && (s_command == tli_pkg::CMD_LOAD)
                                    && (32'(s_entry_index) < 32'(TABLE_DEPTH));
                mem_req.abs_rd_en = 1'b1;
            end
            tli_pkg::ST_CHK_LO: begin
                alu_a             = W'(abs_rd_data);
                alu_b             = W'(q_reg);
                mem_req.abs_rd_en = 1'b1;
                abs_rd_addr       = last_reg;
            end
            tli_pkg::ST_CHK_HI: begin
                alu_a             = W'(q_reg);
                alu_b             = W'(abs_rd_data);
                mem_req.abs_rd_en = 1'b1;
                abs_rd_addr       = AW'(1);
            end
            tli_pkg::ST_SCAN: begin
                alu_a             = W'(q_reg);
                alu_b             = W'(abs_rd_data);
                mem_req.abs_rd_en = 1'b1;
                abs_rd_addr       = idx_reg + AW'(1);
            end
            tli_pkg::ST_SUB_HQ: begin
                alu_a             = W'(hi_reg);
                alu_b             = W'(q_reg);
                mem_req.val_rd_en = 1'b1;
                val_rd_addr       = idx_reg - AW'(1);
            end
            tli_pkg::ST_SUB_QL: begin
                alu_a             = W'(q_reg);
                alu_b             = W'(lo_reg);
                mem_req.val_rd_en = 1'b1;
                val_rd_addr       = idx_reg;
            end
            tli_pkg::ST_SUB_D: begin
                alu_a             = W'(hi_reg);
                alu_b             = W'(lo_reg);
            end
            tli_pkg::ST_MUL: begin
                alu_op            = tli_pkg::ALU_ADD;
                alu_a             = acc_reg;
                alu_b             = mcand_reg;
            end
            tli_pkg::ST_DIV_CHK: begin
                alu_a             = W'(acc_reg[W-1:DATA_WIDTH]);
                alu_b             = W'(d_reg);
            end
            tli_pkg::ST_DIV: begin
                alu_a             = W'(div_shift);
                alu_b             = W'(d_reg);
            end
            tli_pkg::ST_PUSH: begin
                res.valid         = 1'b1;
                res.oor           = oor_reg;
            end
            default: begin
                s_tready          = 1'b0;
            end
        endcase
    end

    // Datapath register updates.
    always_comb begin
        idx_next   = idx_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;
        pass_next  = pass_reg;
        q_next     = q_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        d_next     = d_reg;
        t_next     = t_reg;
        vn_next    = vn_reg;
        mplr_next  = mplr_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        oor_next   = oor_reg;
        case (state_reg)
            tli_pkg::ST_IDLE: begin
                // Latch the query and clamp the breakpoint count to the table.
                if (accept && s_command == tli_pkg::CMD_QUERY) begin
                    q_next   = s_query_abscissa;
                    oor_next = 1'b0;
                    if (pts_ext < 32'd2) begin
                        last_next = AW'(1);
                    end else if (pts_ext > 32'(TABLE_DEPTH)) begin
                        last_next = AW'(TABLE_DEPTH - 1);
                    end else begin
                        last_next = AW'(pts_ext - 32'd1);
                    end
                end
            end
            tli_pkg::ST_CHK_LO: begin
                lo_next = abs_rd_data;
                if (ge) begin
                    res_next = '0;
                    oor_next = 1'b1;
                end
            end
            tli_pkg::ST_CHK_HI: begin
                idx_next = AW'(1);
                if (ge) begin
                    res_next = '0;
                    oor_next = 1'b1;
                end
            end
            tli_pkg::ST_SCAN: begin
                // Move on while the breakpoint does not exceed the query.
                if (ge) begin
                    lo_next  = abs_rd_data;
                    idx_next = idx_reg + AW'(1);
                end else begin
                    hi_next  = abs_rd_data;
                end
            end
            tli_pkg::ST_SUB_HQ: begin
                mplr_next = alu_sum[DATA_WIDTH-1:0];
            end
            tli_pkg::ST_SUB_QL: begin
                t_next     = alu_sum[DATA_WIDTH-1:0];
                mcand_next = W'(val_rd_data);
            end
            tli_pkg::ST_SUB_D: begin
                d_next    = alu_sum[DATA_WIDTH-1:0];
                vn_next   = val_rd_data;
                acc_next  = '0;
                cnt_next  = '0;
                pass_next = 1'b0;
            end
            tli_pkg::ST_MUL: begin
                // One multiplier bit a cycle; the second pass adds v1*(q-a0) to v0*(a1-q).
                if (mplr_reg[0]) begin
                    acc_next = alu_sum;
                end
                mcand_next = mcand_reg << 1;
                mplr_next  = mplr_reg >> 1;
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_done) begin
                    cnt_next = '0;
                    if (!pass_reg) begin
                        pass_next  = 1'b1;
                        mplr_next  = t_reg;
                        mcand_next = W'(vn_reg);
                    end
                end
            end
            tli_pkg::ST_DIV_CHK: begin
                // The quotient overflows exactly when the upper half reaches the divisor.
                if (ge) begin
                    res_next = '1;
                end else begin
                    rem_next = {1'b0, acc_reg[W-1:DATA_WIDTH]};
                    cnt_next = '0;
                end
            end
            tli_pkg::ST_DIV: begin
                // Restoring step: quotient bits shift into the low half of the accumulator.
                rem_next                = ge ? alu_sum[DATA_WIDTH:0] : div_shift;
                acc_next[DATA_WIDTH-1:0] = {acc_reg[DATA_WIDTH-2:0], ge};
                cnt_next                = cnt_reg + CW'(1);
                if (cnt_done) begin
                    res_next = {acc_reg[DATA_WIDTH-2:0], ge};
                end
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tli_pkg::ST_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            pass_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            pass_reg  <= pass_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        last_reg  <= last_next;
        q_reg     <= q_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        d_reg     <= d_next;
        t_reg     <= t_next;
        vn_reg    <= vn_next;
        mplr_reg  <= mplr_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        res_reg   <= res_next;
        oor_reg   <= oor_next;
    end

    // An accepted query always starts with the lower range check.
    `TLI_ASSERT_NEXT(a_query_starts, aclk, aresetn, accept && s_command == tli_pkg::CMD_QUERY, state_reg == tli_pkg::ST_CHK_LO, "query did not start the range check")
    // The scan stops at or before the last breakpoint in use.
    `TLI_ASSERT_IMPL(a_scan_bound, aclk, aresetn, state_reg == tli_pkg::ST_SCAN, idx_reg <= last_reg, "scan ran past the last breakpoint")
    // The partial remainder stays below the divisor throughout the division.
    `TLI_ASSERT_IMPL(a_rem_below_div, aclk, aresetn, state_reg == tli_pkg::ST_DIV, rem_reg < {1'b0, d_reg}, "division remainder reached the divisor")

endmodule

// File: rtl/table_linear_interpolator.sv
// Table linear interpolator: top level with the breakpoint count register and
// the output register. Depends on tli_pkg, tli_alu, tli_table and tli_ctrl.
//
// A load request writes one breakpoint (abscissa and value) and gives no result.
// A query is checked against the first and the last breakpoint in use (out of
// range answers zero with the flag set), then scans the table one breakpoint per
// cycle from slot 1 to the first abscissa above the query, and evaluates
// (v0*(a1-q) + v1*(q-a0)) / (a1-a0) with a truncated, saturating quotient. The
// scan stops at a slot of up to TABLE_DEPTH-1 and uses the single abscissa memory
// read port; the rest runs on one shared adder that does a shift-add multiply of
// 2*DATA_WIDTH steps and a restoring divide of DATA_WIDTH steps. The block takes
// no new request while a query is in work. Table entries hold no value until
// loaded.
`timescale 1ns / 1ps

module table_linear_interpolator #(
    parameter int TABLE_DEPTH = 256,
    parameter int DATA_WIDTH  = 32,
    localparam int AW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int S_TDATA_W = ((tli_pkg::IDX_W + 3 * DATA_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Breakpoint count register.
    input  logic                        cfg_wr_en,
    input  logic [tli_pkg::CFG_W-1:0]   cfg_wr_data,
    // Request stream.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // From bit 0: entry_index, entry_abscissa, entry_value, query_abscissa, zero fill.
    input  logic [S_TDATA_W-1:0]        s_tdata,
    // Bit 0: command.
    input  logic                        s_tuser,
    // Result stream.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // From bit 0: interpolated_value, zero fill.
    output logic [M_TDATA_W-1:0]        m_tdata,
    // Bit 0: out_of_range.
    output logic                        m_tuser
);

    localparam int W      = 2 * DATA_WIDTH;
    localparam int ABS_LO = tli_pkg::IDX_W;
    localparam int VAL_LO = ABS_LO + DATA_WIDTH;
    localparam int QRY_LO = VAL_LO + DATA_WIDTH;

    logic [tli_pkg::CFG_W-1:0] points_reg;
    logic                      m_valid_reg;
    logic [DATA_WIDTH-1:0]     m_value_reg;
    logic                      m_oor_reg;

    logic [tli_pkg::IDX_W-1:0] s_entry_index;
    logic [DATA_WIDTH-1:0]     s_entry_abscissa;
    logic [DATA_WIDTH-1:0]     s_entry_value;
    logic [DATA_WIDTH-1:0]     s_query_abscissa;

    tli_pkg::tli_mem_req_t     mem_req;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             abs_rd_addr;
    logic [AW-1:0]             val_rd_addr;
    logic [DATA_WIDTH-1:0]     abs_rd_data;
    logic [DATA_WIDTH-1:0]     val_rd_data;
    tli_pkg::tli_alu_op_t      alu_op;
    logic [W-1:0]              alu_a;
    logic [W-1:0]              alu_b;
    logic [W-1:0]              alu_sum;
    logic                      alu_carry;
    tli_pkg::tli_res_t         res;
    logic [DATA_WIDTH-1:0]     res_value;
    logic                      out_free;

    // Unpack the request fields.
    assign s_entry_index    = s_tdata[tli_pkg::IDX_W-1:0];
    assign s_entry_abscissa = s_tdata[ABS_LO +: DATA_WIDTH];
    assign s_entry_value    = s_tdata[VAL_LO +: DATA_WIDTH];
    assign s_query_abscissa = s_tdata[QRY_LO +: DATA_WIDTH];

    // Breakpoint count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_reg <= tli_pkg::CFG_RESET;
        end else if (cfg_wr_en) begin
            points_reg <= cfg_wr_data;
        end
    end

    // Output register: a finished result moves in when the slot is empty or drains.
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid && out_free) begin
            m_value_reg <= res_value;
            m_oor_reg   <= res.oor;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_value_reg);
    assign m_tuser  = m_oor_reg;

    tli_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_table (
        .aclk        (aclk),
        .req         (mem_req),
        .wr_addr     (wr_addr),
        .wr_abscissa (s_entry_abscissa),
        .wr_value    (s_entry_value),
        .abs_rd_addr (abs_rd_addr),
        .val_rd_addr (val_rd_addr),
        .abs_rd_data (abs_rd_data),
        .val_rd_data (val_rd_data)
    );

    tli_alu #(
        .W (W)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    tli_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .points_in_use    (points_reg),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_command        (s_tuser),
        .s_entry_index    (s_entry_index),
        .s_query_abscissa (s_query_abscissa),
        .mem_req          (mem_req),
        .wr_addr          (wr_addr),
        .abs_rd_addr      (abs_rd_addr),
        .val_rd_addr      (val_rd_addr),
        .abs_rd_data      (abs_rd_data),
        .val_rd_data      (val_rd_data),
        .alu_op           (alu_op),
        .alu_a            (alu_a),
        .alu_b            (alu_b),
        .alu_sum          (alu_sum),
        .alu_carry        (alu_carry),
        .res              (res),
        .res_value        (res_value),
        .out_free         (out_free)
    );

endmodule
